>>> rtl/rnsc_pkg.sv
// ----------------------------------------------------------------------------
// rnsc_pkg
// Shared types, constants and lookup functions for the Roman numeral pair
// adder: letter decode, greedy symbol table and the queue word format.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rnsc_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 11;
  localparam int SUM_W   = 15;

  // Saturation point of the running total
  localparam logic [SUM_W-1:0] SUM_CAP = 15'd22000;

  // Greedy symbol table: 13 entries, largest first
  localparam int NSYM  = 13;
  localparam int SYM_W = 4;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // ASCII letters
  localparam logic [CHAR_W-1:0] CH_NONE = 8'h00;
  localparam logic [CHAR_W-1:0] CH_I    = 8'h49;
  localparam logic [CHAR_W-1:0] CH_V    = 8'h56;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_L    = 8'h4C;
  localparam logic [CHAR_W-1:0] CH_C    = 8'h43;
  localparam logic [CHAR_W-1:0] CH_D    = 8'h44;
  localparam logic [CHAR_W-1:0] CH_M    = 8'h4D;

  // One finished pair, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] total;
    logic             err;
  } pair_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } bk_state_t;

  // Letter value, zero for anything that is not a numeral letter
  function automatic logic [DIGIT_W-1:0] letter_value(input logic [CHAR_W-1:0] c);
    logic [DIGIT_W-1:0] v;
    unique case (c)
      CH_I:    v = 11'd1;
      CH_V:    v = 11'd5;
      CH_X:    v = 11'd10;
      CH_L:    v = 11'd50;
      CH_C:    v = 11'd100;
      CH_D:    v = 11'd500;
      CH_M:    v = 11'd1000;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Saturating add of a digit to the total; MSB of result flags overflow
  function automatic logic [SUM_W:0] add_sat(input logic [SUM_W-1:0] t,
                                             input logic [DIGIT_W-1:0] a);
    logic [SUM_W:0] s;
    s = {1'b0, t} + (SUM_W+1)'(a);
    if (s > {1'b0, SUM_CAP}) begin
      s = {1'b1, SUM_CAP};
    end
    return s;
  endfunction

  function automatic logic [DIGIT_W-1:0] sym_val(input logic [SYM_W-1:0] i);
    logic [DIGIT_W-1:0] v;
    unique case (i)
      4'd0:    v = 11'd1000;
      4'd1:    v = 11'd900;
      4'd2:    v = 11'd500;
      4'd3:    v = 11'd400;
      4'd4:    v = 11'd100;
      4'd5:    v = 11'd90;
      4'd6:    v = 11'd50;
      4'd7:    v = 11'd40;
      4'd8:    v = 11'd10;
      4'd9:    v = 11'd9;
      4'd10:   v = 11'd5;
      4'd11:   v = 11'd4;
      default: v = 11'd1;
    endcase
    return v;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_first(input logic [SYM_W-1:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      4'd0:                c = CH_M;
      4'd1, 4'd3, 4'd4:    c = CH_C;
      4'd2:                c = CH_D;
      4'd5, 4'd7, 4'd8:    c = CH_X;
      4'd6:                c = CH_L;
      4'd10:               c = CH_V;
      default:             c = CH_I;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] sym_second(input logic [SYM_W-1:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      4'd1:    c = CH_M;
      4'd3:    c = CH_D;
      4'd5:    c = CH_C;
      4'd7:    c = CH_L;
      4'd9:    c = CH_X;
      4'd11:   c = CH_V;
      default: c = CH_NONE;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/rnsc_front.sv
// ----------------------------------------------------------------------------
// rnsc_front
// Character intake: decodes each letter with the subtractive rule, keeps the
// pending digit and running total, and pushes the pair total to the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnsc_front #(
  parameter int MAX_LEN = 11
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [rnsc_pkg::CHAR_W-1:0]      char_code,
  input  logic                             end_of_numeral,
  input  logic                             end_of_pair,
  input  rnsc_pkg::q_stat_t                q_stat,
  output logic                             q_push,
  output rnsc_pkg::pair_t                  q_data
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [rnsc_pkg::DIGIT_W-1:0] pending_value, pending_value_next;
  logic                         pending_valid, pending_valid_next;
  logic [rnsc_pkg::SUM_W-1:0]   running_total, running_total_next;
  logic [CNT_W-1:0]             chars_in_numeral, chars_in_numeral_next;
  logic                         error_seen, error_seen_next;

  logic                         accept;
  logic [rnsc_pkg::DIGIT_W-1:0] v;
  logic                         char_ok;
  logic [rnsc_pkg::DIGIT_W-1:0] add1, add2;
  logic [rnsc_pkg::DIGIT_W-1:0] pval1;
  logic                         pv1;
  logic [rnsc_pkg::SUM_W:0]     t1, t2;

  // Only the closing word of a pair needs room in the queue
  assign in_ready = !q_stat.full || !end_of_pair;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && end_of_pair;

  // Character step, then end-of-numeral flush
  always_comb begin
    v       = rnsc_pkg::letter_value(char_code);
    char_ok = (v != '0) && (chars_in_numeral < CNT_W'(MAX_LEN));
    pval1   = pending_value;
    pv1     = pending_valid;
    add1    = '0;
    add2    = '0;
    chars_in_numeral_next = chars_in_numeral;

    if (char_ok) begin
      chars_in_numeral_next = chars_in_numeral + 1'b1;
      if (!pending_valid) begin
        pval1 = v;
        pv1   = 1'b1;
      end else if (pending_value >= v) begin
        add1  = pending_value;
        pval1 = v;
      end else begin
        add1  = v - pending_value;
        pval1 = '0;
        pv1   = 1'b0;
      end
    end

    t1 = rnsc_pkg::add_sat(running_total, add1);

    pending_value_next = pval1;
    pending_valid_next = pv1;
    if (end_of_numeral || end_of_pair) begin
      add2                  = pv1 ? pval1 : '0;
      pending_value_next    = '0;
      pending_valid_next    = 1'b0;
      chars_in_numeral_next = '0;
    end

    t2 = rnsc_pkg::add_sat(t1[rnsc_pkg::SUM_W-1:0], add2);
    running_total_next = t2[rnsc_pkg::SUM_W-1:0];
    error_seen_next    = error_seen || !char_ok || t1[rnsc_pkg::SUM_W] ||
                         t2[rnsc_pkg::SUM_W];
  end

  assign q_data.total = running_total_next;
  assign q_data.err   = error_seen_next;

  // State registers; a pushed pair starts the next one from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_value    <= '0;
      pending_valid    <= 1'b0;
      running_total    <= '0;
      chars_in_numeral <= '0;
      error_seen       <= 1'b0;
    end else if (accept) begin
      if (end_of_pair) begin
        pending_value    <= '0;
        pending_valid    <= 1'b0;
        running_total    <= '0;
        chars_in_numeral <= '0;
        error_seen       <= 1'b0;
      end else begin
        pending_value    <= pending_value_next;
        pending_valid    <= pending_valid_next;
        running_total    <= running_total_next;
        chars_in_numeral <= chars_in_numeral_next;
        error_seen       <= error_seen_next;
      end
    end
  end

endmodule

>>> rtl/rnsc_queue.sv
// ----------------------------------------------------------------------------
// rnsc_queue
// Two-word queue of finished pair totals between intake and emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnsc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rnsc_pkg::pair_t   wr_data,
  input  logic              pop,
  output rnsc_pkg::pair_t   rd_data,
  output rnsc_pkg::q_stat_t stat
);

  rnsc_pkg::pair_t                mem [rnsc_pkg::Q_DEPTH];
  logic [rnsc_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [rnsc_pkg::QCNT_W-1:0]    count;
  logic                           do_push, do_pop;

  assign stat.full  = (count == rnsc_pkg::QCNT_W'(rnsc_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_data    = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/rnsc_back.sv
// ----------------------------------------------------------------------------
// rnsc_back
// Symbol emitter: takes one pair total from the queue and writes its Roman
// symbols, greedy from the largest, one word per free cycle of the output slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnsc_back (
  input  logic                          clk,
  input  logic                          rst,
  input  rnsc_pkg::q_stat_t             q_stat,
  input  rnsc_pkg::pair_t               q_data,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rnsc_pkg::CHAR_W-1:0]   first_char,
  output logic [rnsc_pkg::CHAR_W-1:0]   second_char,
  output logic [rnsc_pkg::SUM_W-1:0]    sum_value,
  output logic                          is_empty,
  output logic                          bad_input,
  output logic                          last_symbol
);

  rnsc_pkg::bk_state_t          state, state_next;
  logic [rnsc_pkg::SUM_W-1:0]   rest, rest_next;
  logic [rnsc_pkg::SUM_W-1:0]   sum;
  logic                         err;

  logic                         slot_free;
  logic                         load_slot;
  logic [rnsc_pkg::SYM_W-1:0]   sel;
  logic                         last;

  assign slot_free = !out_valid || out_ready;

  // Largest table entry not above the remainder
  always_comb begin
    sel = rnsc_pkg::SYM_W'(rnsc_pkg::NSYM - 1);
    for (int i = rnsc_pkg::NSYM - 1; i >= 0; i--) begin
      if (rest >= rnsc_pkg::SUM_W'(rnsc_pkg::sym_val(rnsc_pkg::SYM_W'(i)))) begin
        sel = rnsc_pkg::SYM_W'(i);
      end
    end
  end

  // Remainder after this symbol; a zero total gives the single empty word
  always_comb begin
    if (rest == '0) begin
      rest_next = '0;
      last      = 1'b1;
    end else begin
      rest_next = rest - rnsc_pkg::SUM_W'(rnsc_pkg::sym_val(sel));
      last      = (rest_next == '0);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      rnsc_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          state_next = rnsc_pkg::BK_EMIT;
        end
      end
      rnsc_pkg::BK_EMIT: begin
        if (slot_free && last) begin
          state_next = rnsc_pkg::BK_IDLE;
        end
      end
      default: state_next = rnsc_pkg::BK_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    load_slot = 1'b0;
    unique case (state)
      rnsc_pkg::BK_IDLE: q_pop     = !q_stat.empty;
      rnsc_pkg::BK_EMIT: load_slot = slot_free;
      default: begin
        q_pop     = 1'b0;
        load_slot = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rnsc_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_slot) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working copy of the pair and the output word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      rest <= q_data.total;
      sum  <= q_data.total;
      err  <= q_data.err;
    end else if (load_slot) begin
      rest <= rest_next;
    end
    if (load_slot) begin
      first_char  <= (rest == '0) ? rnsc_pkg::CH_NONE : rnsc_pkg::sym_first(sel);
      second_char <= (rest == '0) ? rnsc_pkg::CH_NONE : rnsc_pkg::sym_second(sel);
      sum_value   <= sum;
      is_empty    <= (rest == '0);
      bad_input   <= err;
      last_symbol <= last;
    end
  end

endmodule

>>> rtl/roman_numeral_sum_converter_top.sv
// ----------------------------------------------------------------------------
// roman_numeral_sum_converter_top
// Adds two Roman numerals given letter by letter and writes the sum back as
// a burst of Roman symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one letter per word, with
//   end_of_numeral on the last letter of a numeral and end_of_pair on the
//   last letter of the second one. Letters are taken one per cycle; a word
//   carrying end_of_pair waits only while the two-word pair queue is full.
//   Output channel (out_valid/out_ready): one word per Roman symbol of the
//   sum, last_symbol on the final one; a zero sum gives one word with
//   is_empty set. bad_input reports a bad letter, an overlong numeral or a
//   saturated total for that pair.
//   Flow: a pair total reaches the output slot through the pair queue
//   and the emitter's working registers. The emitter writes one symbol per
//   cycle while the receiver is ready, with a pass through its idle state
//   to load each pair; the emitter sequencer is the bound on rate.
//   Receiver stall: the output word holds; the emitter waits, the queue
//   fills, and then only end_of_pair words are held back.
//   Reset clears the running pair total, the queue and the output valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module roman_numeral_sum_converter_top #(
  parameter int MAX_LEN = 11
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rnsc_pkg::CHAR_W-1:0] char_code,
  input  logic                        end_of_numeral,
  input  logic                        end_of_pair,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rnsc_pkg::CHAR_W-1:0] first_char,
  output logic [rnsc_pkg::CHAR_W-1:0] second_char,
  output logic [rnsc_pkg::SUM_W-1:0]  sum_value,
  output logic                        is_empty,
  output logic                        bad_input,
  output logic                        last_symbol
);

  rnsc_pkg::q_stat_t q_stat;
  rnsc_pkg::pair_t   q_wr_data, q_rd_data;
  logic              q_push, q_pop;

  // Intake and decode
  rnsc_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .char_code      (char_code),
    .end_of_numeral (end_of_numeral),
    .end_of_pair    (end_of_pair),
    .q_stat         (q_stat),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // Pair queue
  rnsc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr_data),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .stat    (q_stat)
  );

  // Symbol emitter
  rnsc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_stat      (q_stat),
    .q_data      (q_rd_data),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .first_char  (first_char),
    .second_char (second_char),
    .sum_value   (sum_value),
    .is_empty    (is_empty),
    .bad_input   (bad_input),
    .last_symbol (last_symbol)
  );

endmodule

>>> rtl/rnsc_checker.sv
// ----------------------------------------------------------------------------
// rnsc_checker
// Port-level checks on the converter's output words, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rnsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rnsc_pkg::CHAR_W-1:0] first_char,
  input logic [rnsc_pkg::CHAR_W-1:0] second_char,
  input logic [rnsc_pkg::SUM_W-1:0]  sum_value,
  input logic                        is_empty,
  input logic                        last_symbol
);

  // A stalled word holds its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_char) &&
      $stable(second_char) && $stable(sum_value) && $stable(last_symbol))
    else $error("output word changed while stalled");

  // The empty word stands alone and carries a zero sum
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> last_symbol && first_char == '0 &&
      second_char == '0 && sum_value == '0)
    else $error("malformed empty word");

  // A symbol word always has a letter and a nonzero sum
  a_symbol: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_empty |-> first_char != '0 && sum_value != '0)
    else $error("symbol word without letter or sum");

  // The total never passes its saturation point
  a_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sum_value <= rnsc_pkg::SUM_CAP)
    else $error("sum above saturation point");

  // Nothing is offered straight out of reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind roman_numeral_sum_converter_top rnsc_checker u_rnsc_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .first_char  (first_char),
  .second_char (second_char),
  .sum_value   (sum_value),
  .is_empty    (is_empty),
  .last_symbol (last_symbol)
);

>>> dv/roman_numeral_sum_converter_tb.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Roman numeral pair adder. A scripted table of
// letters (zero sum, both end markers on one word, bad letters, an overlong
// numeral) is followed by random pairs: mostly well-formed numerals, plus
// saturating runs, overlong numerals and junk bytes. A predictor in the
// bench expands each sum into symbol words, and every output word is checked
// field by field. Both sides idle at random, and the receiver holds off once
// for a long stretch so the pair queue fills and input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int NUMERAL_MAX = 11;
  localparam int ITEM_TARGET = 310;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT_WORD = 40;
  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;
  localparam int N_SCRIPT = 22;

  // Shapes of random pair
  typedef enum logic [2:0] {
    SHAPE_PLAIN,
    SHAPE_SINGLE,
    SHAPE_OVERLONG,
    SHAPE_HEAVY,
    SHAPE_NOISE
  } pair_shape_t;

  // One expected output word
  typedef struct {
    logic [rnsc_pkg::CHAR_W-1:0] lead;
    logic [rnsc_pkg::CHAR_W-1:0] trail;
    logic [rnsc_pkg::SUM_W-1:0]  total;
    logic                        blank;
    logic                        flagged;
    logic                        tail;
  } symbol_word_t;

  // One scripted input word; typed rows carry the sum and flag by hand
  typedef struct packed {
    logic [rnsc_pkg::CHAR_W-1:0] code;
    logic                        eon;
    logic                        eop;
    logic                        typed;
    logic [rnsc_pkg::SUM_W-1:0]  sum;
    logic                        bad;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [rnsc_pkg::CHAR_W-1:0] char_code = '0;
  logic                        end_of_numeral = 1'b0;
  logic                        end_of_pair = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [rnsc_pkg::CHAR_W-1:0] first_char;
  logic [rnsc_pkg::CHAR_W-1:0] second_char;
  logic [rnsc_pkg::SUM_W-1:0]  sum_value;
  logic                        is_empty;
  logic                        bad_input;
  logic                        last_symbol;

  // Predictor state for the pair being decoded
  logic [rnsc_pkg::DIGIT_W-1:0] held_digit = '0;
  logic                         held_ok = 1'b0;
  logic [rnsc_pkg::SUM_W-1:0]   pair_total = '0;
  logic [3:0]                   letters_seen = '0;
  logic                         pair_bad = 1'b0;

  symbol_word_t symbols_due[$];
  int n_fail = 0;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit tx_lazy = 1'b0;
  bit rx_lazy = 1'b0;

  script_row_t script_rows [N_SCRIPT] = '{
    '{8'h00,          1'b0, 1'b1, 1'b1, 15'd0,     1'b1},  // bad letter alone: zero sum
    '{rnsc_pkg::CH_I, 1'b1, 1'b1, 1'b1, 15'd1,     1'b0},  // one numeral, both markers
    '{rnsc_pkg::CH_I, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_V, 1'b1, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_X, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_L, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_D, 1'b0, 1'b1, 1'b0, 15'd0,     1'b0},  // end_of_pair alone ends it
    '{rnsc_pkg::CH_C, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{8'hFF,          1'b1, 1'b0, 1'b0, 15'd0,     1'b0},  // bad letter still ends
    '{rnsc_pkg::CH_M, 1'b1, 1'b1, 1'b1, 15'd1100,  1'b1},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b0, 1'b0, 15'd0,     1'b0},
    '{rnsc_pkg::CH_M, 1'b0, 1'b1, 1'b1, 15'd11000, 1'b1}   // twelfth letter is dropped
  };

  roman_numeral_sum_converter_top #(
    .MAX_LEN(NUMERAL_MAX)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .end_of_numeral(end_of_numeral),
    .end_of_pair(end_of_pair),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .first_char(first_char),
    .second_char(second_char),
    .sum_value(sum_value),
    .is_empty(is_empty),
    .bad_input(bad_input),
    .last_symbol(last_symbol)
  );

  always #6 clk = ~clk;

  // Letter weight, zero for junk
  function automatic logic [rnsc_pkg::DIGIT_W-1:0] digit_of(
      input logic [rnsc_pkg::CHAR_W-1:0] c);
    case (c)
      rnsc_pkg::CH_I: return 11'd1;
      rnsc_pkg::CH_V: return 11'd5;
      rnsc_pkg::CH_X: return 11'd10;
      rnsc_pkg::CH_L: return 11'd50;
      rnsc_pkg::CH_C: return 11'd100;
      rnsc_pkg::CH_D: return 11'd500;
      rnsc_pkg::CH_M: return 11'd1000;
      default:        return 11'd0;
    endcase
  endfunction

  // Greedy symbol list, largest first
  function automatic void roman_unit(input int idx, output int unsigned weight,
                                     output logic [rnsc_pkg::CHAR_W-1:0] a,
                                     output logic [rnsc_pkg::CHAR_W-1:0] b);
    b = rnsc_pkg::CH_NONE;
    case (idx)
      0:  begin weight = 1000; a = rnsc_pkg::CH_M; end
      1:  begin weight = 900;  a = rnsc_pkg::CH_C; b = rnsc_pkg::CH_M; end
      2:  begin weight = 500;  a = rnsc_pkg::CH_D; end
      3:  begin weight = 400;  a = rnsc_pkg::CH_C; b = rnsc_pkg::CH_D; end
      4:  begin weight = 100;  a = rnsc_pkg::CH_C; end
      5:  begin weight = 90;   a = rnsc_pkg::CH_X; b = rnsc_pkg::CH_C; end
      6:  begin weight = 50;   a = rnsc_pkg::CH_L; end
      7:  begin weight = 40;   a = rnsc_pkg::CH_X; b = rnsc_pkg::CH_L; end
      8:  begin weight = 10;   a = rnsc_pkg::CH_X; end
      9:  begin weight = 9;    a = rnsc_pkg::CH_I; b = rnsc_pkg::CH_X; end
      10: begin weight = 5;    a = rnsc_pkg::CH_V; end
      11: begin weight = 4;    a = rnsc_pkg::CH_I; b = rnsc_pkg::CH_V; end
      default: begin weight = 1; a = rnsc_pkg::CH_I; end
    endcase
  endfunction

  // Queue the burst of symbol words for one finished sum
  function automatic void expand_sum(input logic [rnsc_pkg::SUM_W-1:0] total,
                                     input logic bad);
    symbol_word_t w;
    int unsigned rest;
    int unsigned weight;
    logic [rnsc_pkg::CHAR_W-1:0] a;
    logic [rnsc_pkg::CHAR_W-1:0] b;
    rest = total;
    w.total = total;
    w.blank = 1'b0;
    w.flagged = bad;
    w.tail = 1'b0;
    if (total == 0) begin
      w.lead = rnsc_pkg::CH_NONE;
      w.trail = rnsc_pkg::CH_NONE;
      w.blank = 1'b1;
      w.tail = 1'b1;
      symbols_due.push_back(w);
      return;
    end
    for (int idx = 0; idx < rnsc_pkg::NSYM; idx++) begin
      roman_unit(idx, weight, a, b);
      while (rest >= weight) begin
        w.lead = a;
        w.trail = b;
        symbols_due.push_back(w);
        rest -= weight;
      end
    end
    // mark the final word of the burst
    w = symbols_due.pop_back();
    w.tail = 1'b1;
    symbols_due.push_back(w);
  endfunction

  // Saturating add into the pair total
  function automatic void add_to_total(input int unsigned d);
    int unsigned s;
    s = pair_total + d;
    if (s > rnsc_pkg::SUM_CAP) begin
      pair_total = rnsc_pkg::SUM_CAP;
      pair_bad = 1'b1;
    end else begin
      pair_total = rnsc_pkg::SUM_W'(s);
    end
  endfunction

  // Advance the decoder by one accepted letter
  function automatic void absorb_letter(input logic [rnsc_pkg::CHAR_W-1:0] c,
                                        input logic eon,
                                        input logic eop, input logic typed,
                                        input logic [rnsc_pkg::SUM_W-1:0] typed_sum,
                                        input logic typed_bad);
    logic [rnsc_pkg::DIGIT_W-1:0] d;
    d = digit_of(c);
    if (d == 0) begin
      pair_bad = 1'b1;
    end else if (letters_seen >= NUMERAL_MAX) begin
      pair_bad = 1'b1;
    end else begin
      letters_seen = letters_seen + 1'b1;
      if (!held_ok) begin
        held_digit = d;
        held_ok = 1'b1;
      end else if (held_digit >= d) begin
        add_to_total(held_digit);
        held_digit = d;
      end else begin
        add_to_total(d - held_digit);
        held_digit = '0;
        held_ok = 1'b0;
      end
    end
    // end of a numeral flushes the held digit
    if (eon || eop) begin
      if (held_ok) begin
        add_to_total(held_digit);
      end
      held_digit = '0;
      held_ok = 1'b0;
      letters_seen = '0;
    end
    if (eop) begin
      if (typed) begin
        expand_sum(typed_sum, typed_bad);
      end else begin
        expand_sum(pair_total, pair_bad);
      end
      pair_total = '0;
      pair_bad = 1'b0;
    end
  endfunction

  // Offer one word after a drawn gap, hold until taken
  task automatic send_letter(input logic [rnsc_pkg::CHAR_W-1:0] c, input logic eon,
                             input logic eop, input logic typed,
                             input logic [rnsc_pkg::SUM_W-1:0] typed_sum,
                             input logic typed_bad);
    int gap;
    if (items_sent % 20 == 0) begin
      tx_lazy = 1'($urandom_range(0, 1));
    end
    gap = tx_lazy ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_numeral <= eon;
    end_of_pair <= eop;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    absorb_letter(c, eon, eop, typed, typed_sum, typed_bad);
  endtask

  function automatic logic [rnsc_pkg::CHAR_W-1:0] pick_letter();
    case ($urandom_range(0, 6))
      0:       return rnsc_pkg::CH_I;
      1:       return rnsc_pkg::CH_V;
      2:       return rnsc_pkg::CH_X;
      3:       return rnsc_pkg::CH_L;
      4:       return rnsc_pkg::CH_C;
      5:       return rnsc_pkg::CH_D;
      default: return rnsc_pkg::CH_M;
    endcase
  endfunction

  // One random pair of numerals, shaped by kind
  task automatic random_pair(input bit force_heavy);
    pair_shape_t shape;
    int draw;
    int n_num;
    int len;
    logic [rnsc_pkg::CHAR_W-1:0] c;
    logic eon;
    logic eop;
    draw = $urandom_range(0, 15);
    if (force_heavy || draw == 13) shape = SHAPE_HEAVY;
    else if (draw < 10) shape = SHAPE_PLAIN;
    else if (draw == 10) shape = SHAPE_SINGLE;
    else if (draw < 13) shape = SHAPE_OVERLONG;
    else shape = SHAPE_NOISE;
    case (shape)
      SHAPE_SINGLE: n_num = 1;
      SHAPE_HEAVY:  n_num = 3;
      SHAPE_NOISE:  n_num = $urandom_range(1, 3);
      default:      n_num = 2;
    endcase
    for (int i = 0; i < n_num; i++) begin
      case (shape)
        SHAPE_SINGLE:   len = $urandom_range(1, NUMERAL_MAX);
        SHAPE_OVERLONG: len = $urandom_range(NUMERAL_MAX - 1, NUMERAL_MAX + 3);
        SHAPE_HEAVY:    len = $urandom_range(9, NUMERAL_MAX);
        SHAPE_NOISE:    len = $urandom_range(1, 5);
        default:        len = $urandom_range(1, 6);
      endcase
      for (int k = 0; k < len; k++) begin
        c = pick_letter();
        if (shape == SHAPE_HEAVY && $urandom_range(0, 7) != 0) begin
          c = rnsc_pkg::CH_M;
        end
        if ((shape == SHAPE_NOISE && $urandom_range(0, 1) == 0) ||
            $urandom_range(0, 31) == 0) begin
          c = rnsc_pkg::CHAR_W'($urandom_range(0, 255));
        end
        eop = (k == len - 1) && (i == n_num - 1);
        eon = (k == len - 1) ? (eop ? 1'($urandom_range(0, 1)) : 1'b1) : 1'b0;
        // junk pairs also break numerals in odd places
        if (shape == SHAPE_NOISE && $urandom_range(0, 3) == 0) begin
          eon = 1'b1;
        end
        send_letter(c, eon, eop, 1'b0, '0, 1'b0);
      end
    end
  endtask

  function automatic void check_field(input string name,
                                      input logic [rnsc_pkg::SUM_W-1:0] want,
                                      input logic [rnsc_pkg::SUM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endfunction

  // Compare each taken output word with the oldest expected one
  always @(posedge clk) begin : check_words
    symbol_word_t w;
    if (!rst && out_valid && out_ready) begin
      if (symbols_due.size() == 0) begin
        $error("word with nothing expected: first_char %0d sum_value %0d",
               first_char, sum_value);
        n_fail++;
      end else begin
        w = symbols_due.pop_front();
        check_field("first_char", rnsc_pkg::SUM_W'(w.lead),
                    rnsc_pkg::SUM_W'(first_char));
        check_field("second_char", rnsc_pkg::SUM_W'(w.trail),
                    rnsc_pkg::SUM_W'(second_char));
        check_field("sum_value", w.total, sum_value);
        check_field("is_empty", rnsc_pkg::SUM_W'(w.blank),
                    rnsc_pkg::SUM_W'(is_empty));
        check_field("bad_input", rnsc_pkg::SUM_W'(w.flagged),
                    rnsc_pkg::SUM_W'(bad_input));
        check_field("last_symbol", rnsc_pkg::SUM_W'(w.tail),
                    rnsc_pkg::SUM_W'(last_symbol));
      end
    end
  end

  // Receiver: random stalls, one long hold-off to back up the queue
  initial begin : sink
    int stall;
    int taken;
    taken = 0;
    forever begin
      if (taken % 20 == 0) begin
        rx_lazy = 1'($urandom_range(0, 1));
      end
      stall = rx_lazy ? $urandom_range(0, 19) : 0;
      if (taken == HOLD_AT_WORD) begin
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Main sequence
  initial begin : stimulus
    int pairs_made;
    pairs_made = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < N_SCRIPT; r++) begin
      send_letter(script_rows[r].code, script_rows[r].eon, script_rows[r].eop,
                  script_rows[r].typed, script_rows[r].sum, script_rows[r].bad);
    end
    // first random pair is always a heavy one, mostly M letters, aimed at saturating the total
    while (items_sent < ITEM_TARGET) begin
      random_pair(pairs_made == 0);
      pairs_made++;
    end
    in_valid <= 1'b0;
    while (symbols_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
